// ===== src/ssdc_pkg.sv =====
// shared types, constants and the segment decode for the stepped decimal counter
// no dependencies
package ssdc_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int POS_W       = 2;
  localparam int BCD_W       = 4;
  localparam int VALUE_W     = 14;
  localparam int HOLD_W      = 10;
  localparam int SWITCH_W    = 4;
  localparam int ENABLE_W    = 4;
  localparam int SEG_W       = 8;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 32;

  localparam logic [HOLD_W-1:0]    HOLD_RESET    = 10'd125;
  localparam logic [VALUE_W:0]     COUNT_MODULUS = 15'd10000;
  localparam logic [VALUE_W:0]     STEP_ADD_ONE  = 15'd1;
  localparam logic [VALUE_W:0]     STEP_ADD_TEN  = 15'd10;
  localparam logic [VALUE_W:0]     STEP_SUB_ONE  = 15'd9999;
  localparam logic [VALUE_W:0]     STEP_SUB_TEN  = 15'd9990;
  localparam logic [BCD_W-1:0]     BCD_MAX       = 4'd9;
  localparam logic [POS_W-1:0]     POS_ONES      = 2'd3;
  localparam logic [ENABLE_W-1:0]  ENABLE_FIRST  = 4'b1000;

  // carry or borrow handed from one digit cell to the next
  typedef struct packed {
    logic inc;
    logic dec;
  } carry_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hd8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hc0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/ssdc_digit_cell.sv =====
// one decimal digit of the counter, with carry and borrow to the next cell
// depends on ssdc_pkg
module ssdc_digit_cell
  import ssdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  carry_t           cin,
  output carry_t           cout,
  output logic [BCD_W-1:0] digit
);

  logic [BCD_W-1:0] digit_next;

  always_comb begin
    digit_next = digit;
    cout       = '0;
    if (cin.inc) begin
      if (digit == BCD_MAX) begin
        digit_next = '0;
        cout.inc   = 1'b1;
      end else begin
        digit_next = digit + 4'd1;
      end
    end else if (cin.dec) begin
      if (digit == '0) begin
        digit_next = BCD_MAX;
        cout.dec   = 1'b1;
      end else begin
        digit_next = digit - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
    end else if (en) begin
      digit <= digit_next;
    end
  end

endmodule

// ===== src/switch_stepped_decimal_display_counter.sv =====
// top level of the switch stepped four digit display counter
// depends on ssdc_pkg and ssdc_digit_cell
//
// usage:
//   s_* carries one scan tick per transfer; s_tdata[3:0] holds the switch levels
//   (bit0 +1, bit1 +10, bit2 -1, bit3 -10, lowest pressed bit wins).
//   m_* returns one result per tick: digit enable, active-low segments,
//   counter value after the tick and a changed flag.
//   cfg_we / cfg_wdata load the number of scans to hold after a change.
// timing:
//   each result is registered when its tick is accepted; a tick can be taken in
//   every cycle while the single output register is empty or being read.
//   the digits are a row of four bcd cells with a ripple carry chain,
//   so a change settles within the accepting cycle.
// reset:
//   value 0, thousands digit next, no hold, hold setting 125, output empty.
// stall:
//   while m_tready is low and a result is held, s_tready is low and no
//   counter, scan or hold state changes.
module switch_stepped_decimal_display_counter
  import ssdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] switch_pressed
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] digit_enable, [11:4] segment_pattern,
                                           // [25:12] shown_value, [26] value_changed
  input  logic                  cfg_we,
  input  logic [HOLD_W-1:0]     cfg_wdata
);

  logic [HOLD_W-1:0]   repeat_hold_scans;
  logic [HOLD_W-1:0]   hold_remaining;
  logic [POS_W-1:0]    digit_position;
  logic [VALUE_W-1:0]  counter_value;
  logic [VALUE_W-1:0]  counter_value_next;
  logic                accept;
  logic                scan_end;
  logic                hit;
  logic                update;
  logic [SWITCH_W-1:0] sw;
  logic [VALUE_W:0]    step;
  logic [VALUE_W:0]    sum;
  logic [BCD_W-1:0]    digits [DIGIT_COUNT];
  carry_t              chain  [1:DIGIT_COUNT];
  carry_t              ones_in;
  carry_t              tens_in;
  logic [BCD_W-1:0]    shown_digit;
  logic [ENABLE_W-1:0] enable;
  logic [SEG_W-1:0]    pattern;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign sw       = s_tdata[SWITCH_W-1:0];
  assign scan_end = (digit_position == POS_ONES);
  assign hit      = |sw;
  assign update   = accept && scan_end && (hold_remaining == '0) && hit;

  // priority pick of the step, lowest bit first
  always_comb begin
    step = '0;
    if (sw[0]) begin
      step = STEP_ADD_ONE;
    end else if (sw[1]) begin
      step = STEP_ADD_TEN;
    end else if (sw[2]) begin
      step = STEP_SUB_ONE;
    end else if (sw[3]) begin
      step = STEP_SUB_TEN;
    end
    sum = {1'b0, counter_value} + step;
    if (sum >= COUNT_MODULUS) begin
      sum = sum - COUNT_MODULUS;
    end
    counter_value_next = sum[VALUE_W-1:0];
  end

  // digit cells: index 0 is ones, 3 is thousands
  always_comb begin
    ones_in.inc = sw[0];
    ones_in.dec = !sw[0] && !sw[1] && sw[2];
    tens_in.inc = chain[1].inc || (!sw[0] && sw[1]);
    tens_in.dec = chain[1].dec || (!sw[0] && !sw[1] && !sw[2] && sw[3]);
  end

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
    carry_t cell_in;
    if (i == 0) begin : g_ones
      assign cell_in = ones_in;
    end else if (i == 1) begin : g_tens
      assign cell_in = tens_in;
    end else begin : g_upper
      assign cell_in = chain[i];
    end
    ssdc_digit_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (update),
      .cin   (cell_in),
      .cout  (chain[i+1]),
      .digit (digits[i])
    );
  end

  always_comb begin
    shown_digit = digits[POS_ONES - digit_position];
    enable      = ENABLE_FIRST >> digit_position;
    pattern     = seg_decode(shown_digit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_hold_scans <= HOLD_RESET;
    end else if (cfg_we) begin
      repeat_hold_scans <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_position <= '0;
      hold_remaining <= '0;
      counter_value  <= '0;
    end else if (accept) begin
      digit_position <= digit_position + 2'd1;
      if (scan_end) begin
        if (hold_remaining != '0) begin
          hold_remaining <= hold_remaining - 10'd1;
        end else if (hit) begin
          hold_remaining <= repeat_hold_scans;
          counter_value  <= counter_value_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, update, (update ? counter_value_next : counter_value),
                  pattern, enable};
    end
  end

endmodule

// ===== verif/tb_switch_stepped_decimal_display_counter.sv =====
`timescale 1ns / 100ps
// testbench for the switch stepped four digit display counter: directed and random scan ticks
// checked against an in-bench model of the digit scan, switch sampling and hold count
// depends on ssdc_pkg and switch_stepped_decimal_display_counter
module tb_switch_stepped_decimal_display_counter;
  import ssdc_pkg::*;

  localparam logic [SWITCH_W-1:0] SW_NONE    = 4'b0000;
  localparam logic [SWITCH_W-1:0] SW_ADD_ONE = 4'b0001;
  localparam logic [SWITCH_W-1:0] SW_ADD_TEN = 4'b0010;
  localparam logic [SWITCH_W-1:0] SW_SUB_ONE = 4'b0100;
  localparam logic [SWITCH_W-1:0] SW_SUB_TEN = 4'b1000;
  localparam logic [SWITCH_W-1:0] SW_ALL     = 4'b1111;
  localparam int                  MODULUS    = 10000;
  localparam int                  HOLDOFF_CYCLES = 40;
  localparam logic [HOLD_W-1:0]   HOLD_MAX   = 10'd1023;

  localparam logic [SEG_W-1:0] GLYPH [0:9] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hd8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic [ENABLE_W-1:0] enable;
    logic [SEG_W-1:0]    segments;
    logic [VALUE_W-1:0]  value;
    logic                changed;
  } tick_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [HOLD_W-1:0]     cfg_wdata;

  // display model state
  logic [VALUE_W-1:0] cnt_value;
  logic [POS_W-1:0]   cnt_pos;
  logic [HOLD_W-1:0]  hold_left;
  logic [HOLD_W-1:0]  hold_setting;

  tick_result_t tick_results_q[$];
  int err_count    = 0;
  int tick_count   = 0;
  int change_count = 0;
  int holdoff_left = 0;
  int ready_gap    = 0;
  bit idle_on      = 1'b1;

  switch_stepped_decimal_display_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_result_t advance_scan(input logic [SWITCH_W-1:0] sw);
    tick_result_t r;
    int digit;
    int nxt;
    case (cnt_pos)
      2'd0:    digit = cnt_value / 1000;
      2'd1:    digit = (cnt_value / 100) % 10;
      2'd2:    digit = (cnt_value / 10) % 10;
      default: digit = cnt_value % 10;
    endcase
    r.enable   = ENABLE_FIRST >> cnt_pos;
    r.segments = GLYPH[digit];
    r.changed  = 1'b0;
    if (cnt_pos == POS_ONES) begin
      if (hold_left == 0) begin
        nxt = cnt_value;
        // lowest pressed switch wins
        if ((sw & SW_ADD_ONE) != SW_NONE) nxt = nxt + 1;
        else if ((sw & SW_ADD_TEN) != SW_NONE) nxt = nxt + 10;
        else if ((sw & SW_SUB_ONE) != SW_NONE) nxt = nxt + MODULUS - 1;
        else if ((sw & SW_SUB_TEN) != SW_NONE) nxt = nxt + MODULUS - 10;
        if (sw != SW_NONE) begin
          cnt_value = VALUE_W'(nxt % MODULUS);
          hold_left = hold_setting;
          r.changed = 1'b1;
          change_count++;
        end
      end else begin
        hold_left = hold_left - 1'b1;
      end
    end
    cnt_pos = cnt_pos + 1'b1;
    r.value = cnt_value;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SWITCH_W-1:0] pick_switches();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SW_ADD_ONE << $urandom_range(0, 3);
    if (r < 8) return SWITCH_W'($urandom_range(0, 15));
    return SW_NONE;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_tick(input logic [SWITCH_W-1:0] sw);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(sw);
    do @(posedge clk); while (!s_tready);
    tick_results_q.push_back(advance_scan(sw));
    tick_count++;
    @(negedge clk);
  endtask

  task automatic sender_pause();
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tick_results_q.size() > 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we       <= 1'b0;
    hold_setting = v;
    @(negedge clk);
  endtask

  task automatic test_reset_display();
    repeat (4) begin
      send_tick((cnt_pos == POS_ONES) ? SW_NONE : SW_ALL);
      sender_pause();
    end
  endtask

  task automatic test_switch_actions();
    logic [SWITCH_W-1:0] acts [0:5];
    acts = '{SW_SUB_ONE, SW_ADD_ONE, SW_SUB_TEN, SW_ADD_TEN, SW_ALL, 4'b1100};
    write_hold('0);
    foreach (acts[i]) begin
      while (cnt_pos != POS_ONES) send_tick(SW_ALL);
      send_tick(acts[i]);
      sender_pause();
    end
  endtask

  task automatic test_random_scans(input logic [HOLD_W-1:0] hold, input int n, input bit idling);
    write_hold(hold);
    idle_on = idling;
    repeat (n) begin
      send_tick(pick_switches());
      sender_pause();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    write_hold('0);
    idle_on      = 1'b0;
    holdoff_left = HOLDOFF_CYCLES;
    repeat (24) send_tick(pick_switches());
    idle_on = 1'b1;
  endtask

  // receiver side
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        m_tready <= 1'b0;
        holdoff_left--;
      end else if (ready_gap > 0) begin
        m_tready <= 1'b0;
        ready_gap--;
      end else begin
        m_tready  <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.enable   = m_tdata[3:0];
      got.segments = m_tdata[11:4];
      got.value    = m_tdata[25:12];
      got.changed  = m_tdata[26];
      if (tick_results_q.size() == 0) begin
        $error("unexpected transfer, m_tdata %h", m_tdata);
        err_count++;
      end else begin
        want = tick_results_q.pop_front();
        if (got.enable !== want.enable) begin
          $error("digit_enable expected %h got %h", want.enable, got.enable);
          err_count++;
        end
        if (got.segments !== want.segments) begin
          $error("segment_pattern expected %h got %h", want.segments, got.segments);
          err_count++;
        end
        if (got.value !== want.value) begin
          $error("shown_value expected %0d got %0d", want.value, got.value);
          err_count++;
        end
        if (got.changed !== want.changed) begin
          $error("value_changed expected %b got %b", want.changed, got.changed);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    cnt_value    = '0;
    cnt_pos      = '0;
    hold_left    = '0;
    hold_setting = HOLD_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_display();
    test_switch_actions();
    test_random_scans('0, 260, 1'b1);
    test_random_scans(10'd1, 260, 1'b0);
    test_random_scans(10'd2, 260, 1'b1);
    test_random_scans(10'd3, 260, 1'b1);
    test_random_scans(HOLD_W'($urandom_range(4, 20)), 260, 1'b1);
    test_random_scans('0, 200, 1'b0);
    test_output_stall();
    test_random_scans(HOLD_MAX, 60, 1'b1);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("covered %0d ticks with %0d counter changes, hold settings 0 through 1023",
             tick_count, change_count);
    $display("output held off for %0d cycles with ticks still offered", HOLDOFF_CYCLES);
    if (err_count == 0 && tick_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
